/* hw/rtl/zrrf_pkg.sv */
// shared types and constants for the zero run range finder
`default_nettype none
package zrrf_pkg;

  localparam int POS_BITS   = 48;
  localparam int MIN_BITS   = 32;
  localparam int SHIFT_BITS = 5;
  localparam int BYTE_BITS  = 8;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [MIN_BITS-1:0]   MIN_RUN_RESET = MIN_BITS'(4096);
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET   = SHIFT_BITS'(12);

  localparam int CFG_ADDR_BITS = 1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_RUN = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLUSTER = 1'b1;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam int OUT_TDATA_BITS = 2 * POS_BITS;

  // a closed run, or the end of the stream, handed from front to back
  typedef struct packed {
    logic                run_open;
    logic [POS_BITS-1:0] run_begin;
    logic [POS_BITS-1:0] run_count;
    logic                last;
  } zrrf_event_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
    sat_inc = (x == POS_MAX) ? x : x + POS_BITS'(1);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/zrrf_front.sv */
// front end: byte position, run tracking, close events
`default_nettype none
module zrrf_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [zrrf_pkg::BYTE_BITS-1:0] s_tdata,
  input  wire logic                           s_tlast,
  input  wire logic                           q_full,
  output logic                                push,
  output zrrf_pkg::zrrf_event_t               push_event
);

  logic [zrrf_pkg::POS_BITS-1:0] byte_position;
  logic [zrrf_pkg::POS_BITS-1:0] run_begin;
  logic [zrrf_pkg::POS_BITS-1:0] run_count;
  logic                          in_zero_run;

  logic                          accept;
  logic                          is_zero;
  logic [zrrf_pkg::POS_BITS-1:0] begin_base;
  logic [zrrf_pkg::POS_BITS-1:0] count_inc;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_zero  = (s_tdata == '0);

  assign begin_base = in_zero_run ? run_begin : byte_position;
  assign count_inc  = zrrf_pkg::sat_inc(in_zero_run ? run_count : '0);

  // a zero byte extends the run before any close on the last byte
  always_comb begin
    push_event.last = s_tlast;
    if (is_zero) begin
      push_event.run_open  = 1'b1;
      push_event.run_begin = begin_base;
      push_event.run_count = count_inc;
    end else begin
      push_event.run_open  = in_zero_run;
      push_event.run_begin = run_begin;
      push_event.run_count = run_count;
    end
  end

  assign push = accept && (s_tlast || (!is_zero && in_zero_run));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      run_begin     <= '0;
      run_count     <= '0;
      in_zero_run   <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_position <= '0;
        run_begin     <= '0;
        run_count     <= '0;
        in_zero_run   <= 1'b0;
      end else begin
        byte_position <= zrrf_pkg::sat_inc(byte_position);
        if (is_zero) begin
          run_begin   <= begin_base;
          run_count   <= count_inc;
          in_zero_run <= 1'b1;
        end else begin
          in_zero_run <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/zrrf_queue.sv */
// short event queue between front and back
`default_nettype none
module zrrf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire zrrf_pkg::zrrf_event_t push_event,
  output logic                       full,
  input  wire logic                  pop,
  output zrrf_pkg::zrrf_event_t      head,
  output logic                       nonempty
);

  zrrf_pkg::zrrf_event_t store [zrrf_pkg::QDEPTH];

  logic [zrrf_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [zrrf_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [zrrf_pkg::QCNT_BITS-1:0] count;

  assign full     = (count == zrrf_pkg::QCNT_BITS'(zrrf_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign head     = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + zrrf_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + zrrf_pkg::QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + zrrf_pkg::QCNT_BITS'(1);
        2'b01:   count <= count - zrrf_pkg::QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/zrrf_back.sv */
// back end: qualify, align to clusters, output register
`default_nettype none
module zrrf_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [zrrf_pkg::MIN_BITS-1:0]    min_run_length,
  input  wire logic [zrrf_pkg::SHIFT_BITS-1:0]  cluster_shift,
  input  wire zrrf_pkg::zrrf_event_t            head,
  input  wire logic                             nonempty,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [zrrf_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                  m_tuser,
  output logic                                  m_tlast
);

  localparam int PB = zrrf_pkg::POS_BITS;

  // stage 1 compute
  logic          qual;
  logic [PB:0]   end_sum;
  logic [PB-1:0] run_end;
  logic [PB-1:0] csize;
  logic [PB-1:0] cmask;
  logic [PB-1:0] lo_base;
  logic          need_round;
  logic          round_ovf;
  logic [PB-1:0] lo_next;
  logic [PB-1:0] hi_next;
  logic          keep_next;

  // stage 1 registers
  logic          s1_valid;
  logic          s1_keep;
  logic          s1_last;
  logic [PB-1:0] s1_lo;
  logic [PB-1:0] s1_hi;

  // output register
  logic          out_valid;
  logic          out_range;
  logic          out_last;
  logic [PB-1:0] out_start;
  logic [PB-1:0] out_len;

  logic          range_ok;
  logic          emit;
  logic          out_load;
  logic          s1_move;
  logic          s1_load;

  assign qual    = head.run_open &&
                   (head.run_count >= PB'(min_run_length));
  assign end_sum = {1'b0, head.run_begin} + {1'b0, head.run_count};
  assign run_end = end_sum[PB] ? zrrf_pkg::POS_MAX : end_sum[PB-1:0];

  assign csize      = PB'(1) << cluster_shift;
  assign cmask      = csize - PB'(1);
  assign lo_base    = head.run_begin & ~cmask;
  assign need_round = |(head.run_begin & cmask);
  assign round_ovf  = lo_base > (zrrf_pkg::POS_MAX - csize);
  assign lo_next    = need_round ? lo_base + csize : lo_base;
  assign hi_next    = run_end & ~cmask;
  assign keep_next  = qual && !(need_round && round_ovf);

  assign range_ok = s1_keep && (s1_hi > s1_lo);
  assign emit     = range_ok || s1_last;
  assign out_load = s1_valid && emit && (!out_valid || m_tready);
  assign s1_move  = s1_valid && (!emit || !out_valid || m_tready);
  assign s1_load  = !s1_valid || s1_move;
  assign pop      = nonempty && s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_keep <= keep_next;
      s1_last <= head.last;
      s1_lo   <= lo_next;
      s1_hi   <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // range fields read as zero when no range is carried
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_range <= range_ok;
      out_last  <= s1_last;
      out_start <= range_ok ? s1_lo : '0;
      out_len   <= range_ok ? s1_hi - s1_lo : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_start};
  assign m_tuser  = out_range;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

/* hw/rtl/zero_run_range_finder.sv */
// top level of the zero run range finder
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata[7:0] data_byte, tlast last_byte
//  m_      | out | m_tvalid/m_tready  | tdata[47:0] range_start, [95:48] range_length,
//          |     |                    | tuser range_valid, tlast stream_end
//  cfg_    | in  | cfg_we             | cfg_addr register index, cfg_data value
//
// one byte is taken every cycle while the queue is not full; the per-byte run update sits in the front end
// a result passes through the queue, the align stage and the output register
// a four-entry event queue lets the front keep taking bytes while the output stalls
// rst is synchronous; it clears position, run state, queue and both back stages
// s_tready drops only when the queue is full
`default_nettype none
module zero_run_range_finder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [zrrf_pkg::BYTE_BITS-1:0]       s_tdata,   // data_byte
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [zrrf_pkg::OUT_TDATA_BITS-1:0]       m_tdata,   // range_start, range_length
  output logic                                      m_tuser,   // range_valid
  output logic                                      m_tlast,
  input  wire logic                                 cfg_we,
  input  wire logic [zrrf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire logic [zrrf_pkg::MIN_BITS-1:0]        cfg_data
);

  localparam int PB = zrrf_pkg::POS_BITS;

  logic [zrrf_pkg::MIN_BITS-1:0]   min_run_length;
  logic [zrrf_pkg::SHIFT_BITS-1:0] cluster_shift;

  logic                  q_full;
  logic                  q_nonempty;
  logic                  push;
  logic                  pop;
  zrrf_pkg::zrrf_event_t push_event;
  zrrf_pkg::zrrf_event_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_length <= zrrf_pkg::MIN_RUN_RESET;
      cluster_shift  <= zrrf_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        zrrf_pkg::REG_MIN_RUN: min_run_length <= cfg_data;
        zrrf_pkg::REG_CLUSTER: cluster_shift  <= cfg_data[zrrf_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  zrrf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_event (push_event)
  );

  zrrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .nonempty   (q_nonempty)
  );

  zrrf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .min_run_length (min_run_length),
    .cluster_shift  (cluster_shift),
    .head           (head),
    .nonempty       (q_nonempty),
    .pop            (pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

  // a reported range is never empty
  a_range_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[2*PB-1:PB] != '0)
    else $error("empty range reported");

  // a reported range starts on a cluster boundary
  a_range_aligned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      ((m_tdata[PB-1:0] >> cluster_shift) << cluster_shift) == m_tdata[PB-1:0])
    else $error("range start not cluster aligned");

  // without a range, range fields are zero
  a_no_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("range fields set without a range");

  // a result without a range only comes from the end of the stream
  a_end_or_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser || m_tlast)
    else $error("result carries neither range nor stream end");

endmodule
`default_nettype wire
